// ===== rtl/fcc_pkg.sv =====
// Shared types, constants and codes of the FAT12 cluster chain cursor.
package fcc_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int PAIR_DEPTH    = TABLE_ENTRIES / 2;
	localparam int PAIR_AW       = $clog2(PAIR_DEPTH);

	localparam int CLUS_W  = 12;
	localparam int CSIZE_W = 16;
	localparam int POS_W   = 32;
	localparam int ADDR_W  = 28;
	localparam int SEEK_W  = 37;
	localparam int DIV_W   = 33;
	localparam int STEP_W  = 33;
	localparam int CNT_W   = $clog2(DIV_W);

	localparam logic [CLUS_W-1:0]  END_CHAIN   = 12'hfff;
	localparam logic [CLUS_W-1:0]  LIMIT_RST   = 12'hff7;
	localparam logic [CSIZE_W-1:0] CSIZE_RST   = 16'd512;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_SEEK = 2'd2;

	localparam logic [1:0] ORG_START = 2'd0;
	localparam logic [1:0] ORG_CUR   = 2'd1;
	localparam logic [1:0] ORG_END   = 2'd2;

	localparam logic [1:0] REG_CLUSTER_SIZE  = 2'd0;
	localparam logic [1:0] REG_CLUSTER_LIMIT = 2'd1;
	localparam logic [1:0] REG_START_CLUSTER = 2'd2;
	localparam logic [1:0] REG_FILE_SIZE     = 2'd3;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_EOF = 2'd1,
		STAT_BAD = 2'd2
	} stat_code_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_LOAD,
		DP_RD_MUL,
		DP_RD_FOLLOW,
		DP_RD_ADDR,
		DP_SK_MAX,
		DP_SK_ORG,
		DP_SK_CLAMP,
		DP_SK_NEG,
		DP_SK_NEG2,
		DP_SK_REST,
		DP_SK_SHORT,
		DP_SK_LONG,
		DP_SK_ACC,
		DP_WK_INIT,
		DP_WK_STEP,
		DP_WK_NEXT,
		DP_WK_BAD,
		DP_WK_MOD,
		DP_WK_SETREM,
		DP_WK_FIN
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RD_CHK,
		ST_RD_FOL,
		ST_RD_ADDR,
		ST_SK_MAX,
		ST_SK_ORG,
		ST_SK_CLAMP,
		ST_SK_NEG,
		ST_SK_NEG2,
		ST_SK_REST,
		ST_SK_DIST,
		ST_SK_ACC,
		ST_SK_DIV,
		ST_WK_CHK,
		ST_WK_RD,
		ST_WK_MODW,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t     op;
		logic       st_we;
		stat_code_t st;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       cur_bad;
		logic       off_in;
		logic       at_eof;
		logic       short_seek;
		logic       div_done;
		logic       steps_zero;
		logic       cyc_hit;
		logic       next_bad;
		logic       out_free;
	} dp_stat_t;

endpackage

// ===== rtl/fat12_cluster_chain_cursor.sv =====
// A load writes one table pair; a read follows the chain into each next cluster as needed,
// then gives the byte address, or ends with end of file or a bad cluster.
// Seek: within the current cluster the cursor moves without a walk; else a divide by cluster size
// sets the clusters to walk; a chain loop starts a second divide. Output stalls hold the result.
// Throughput: one transaction at a time; the next is taken while the result waits.
// Reset: cursor cleared, registers at their defaults, table contents undefined.
module fat12_cluster_chain_cursor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [10:0]        pair_index,
	input  logic [23:0]        packed_bytes,
	input  logic signed [31:0] seek_offset,
	input  logic [1:0]         seek_origin,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [27:0]        byte_address,
	output logic signed [31:0] residual,
	output logic [31:0]        position,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	fcc_pkg::dp_cmd_t  cmd;
	fcc_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	fcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	fcc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.pair_index   (pair_index),
		.packed_bytes (packed_bytes),
		.seek_offset  (seek_offset),
		.seek_origin  (seek_origin),
		.cfg_valid    (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.byte_address (byte_address),
		.residual     (residual),
		.position     (position)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction taken while one is in progress");

	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != fcc_pkg::STAT_OK)) |-> (byte_address == '0))
		else $error("byte address given with a failing status");

	a_res_only_seek: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (residual != '0)) |-> (byte_address == '0))
		else $error("residual and byte address both set");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("undefined status code");

endmodule

// ===== rtl/fcc_table.sv =====
// Cluster table store: pairs of 12-bit entries, one pair written per load.
module fcc_table (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [10:0]                               pair_index,
	input  logic [23:0]                               packed_bytes,
	input  logic [fcc_pkg::CLUS_W-1:0]                raddr,
	output logic [fcc_pkg::CLUS_W-1:0]                rdata
);

	logic [23:0] mem [fcc_pkg::PAIR_DEPTH];
	logic [23:0] rd_q;
	logic        half_q;
	logic        oor_q;

	always_ff @(posedge clk) begin
		if (we && (int'(pair_index) < fcc_pkg::PAIR_DEPTH)) begin
			mem[pair_index[fcc_pkg::PAIR_AW-1:0]] <= packed_bytes;
		end
	end

	always_ff @(posedge clk) begin
		rd_q   <= mem[raddr[fcc_pkg::PAIR_AW:1]];
		half_q <= raddr[0];
		oor_q  <= (int'(raddr) >= fcc_pkg::TABLE_ENTRIES);
	end

	// odd entry sits in the upper twelve bits of the pair
	assign rdata = oor_q  ? fcc_pkg::END_CHAIN :
	               half_q ? rd_q[23:12] : rd_q[11:0];

endmodule

// ===== rtl/fcc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module fcc_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fcc_pkg::DIV_W-1:0]  dividend,
	input  logic [15:0]                divisor,
	output logic [fcc_pkg::DIV_W-1:0]  quotient,
	output logic [15:0]                remainder,
	output logic                       done
);

	logic                       busy_q;
	logic                       done_q;
	logic [fcc_pkg::CNT_W-1:0]  cnt_q;
	logic [fcc_pkg::DIV_W-1:0]  quo_q;
	logic [15:0]                rem_q;
	logic [15:0]                dvs_q;
	logic [16:0]                trial;
	logic [17:0]                diff;
	logic                       ge;

	assign trial = {rem_q, quo_q[fcc_pkg::DIV_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = ~diff[17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			cnt_q <= fcc_pkg::CNT_W'(fcc_pkg::DIV_W - 1);
		end else if (busy_q) begin
			quo_q <= {quo_q[fcc_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[15:0] : trial[15:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// ===== rtl/fcc_datapath.sv =====
// Datapath: cursor state, configuration, seek arithmetic, chain walk and output register.
module fcc_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fcc_pkg::dp_cmd_t          cmd,
	output fcc_pkg::dp_stat_t         stat,
	input  logic [1:0]                action,
	input  logic [10:0]               pair_index,
	input  logic [23:0]               packed_bytes,
	input  logic signed [31:0]        seek_offset,
	input  logic [1:0]                seek_origin,
	input  logic                      cfg_valid,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [1:0]                status,
	output logic [27:0]               byte_address,
	output logic signed [31:0]        residual,
	output logic [31:0]               position
);

	localparam int SW = fcc_pkg::SEEK_W;

	// cursor and configuration
	logic [fcc_pkg::CLUS_W-1:0]  cur_q;
	logic [fcc_pkg::CSIZE_W-1:0] coff_q;
	logic [fcc_pkg::POS_W-1:0]   pos_q;
	logic [fcc_pkg::CSIZE_W-1:0] csize_q;
	logic [fcc_pkg::CLUS_W-1:0]  limit_q;
	logic [fcc_pkg::CLUS_W-1:0]  start_q;
	logic [fcc_pkg::POS_W-1:0]   fsize_q;
	logic                        out_valid_q;

	// working registers
	logic [1:0]                  act_q;
	logic [1:0]                  org_q;
	logic [10:0]                 pidx_q;
	logic [23:0]                 pbytes_q;
	logic signed [SW-1:0]        offs_q;
	logic signed [SW-1:0]        maxoff_q;
	logic signed [SW-1:0]        res_q;
	logic [fcc_pkg::CSIZE_W-1:0] rest_q;
	logic [fcc_pkg::POS_W-1:0]   acc_q;
	logic [fcc_pkg::ADDR_W-1:0]  mul_q;
	logic [fcc_pkg::ADDR_W-1:0]  addr_q;
	fcc_pkg::stat_code_t         st_q;
	logic [fcc_pkg::STEP_W-1:0]  steps_q;
	logic [15:0]                 drem_q;
	logic [fcc_pkg::CLUS_W-1:0]  saved_q;
	logic [15:0]                 lam_q;
	logic [15:0]                 pow_q;
	logic                        cyc_q;
	logic                        first_q;

	// output register
	logic [1:0]                  ost_q;
	logic [27:0]                 oaddr_q;
	logic signed [31:0]          ores_q;
	logic [31:0]                 opos_q;

	logic [fcc_pkg::CSIZE_W-1:0] cs_eff;
	logic signed [SW-1:0]        fs_ext;
	logic signed [SW-1:0]        pos_ext;
	logic signed [SW-1:0]        rest_ext;
	logic [fcc_pkg::CLUS_W-1:0]  tbl_rdata;
	logic                        div_start;
	logic [fcc_pkg::DIV_W-1:0]   div_dvd;
	logic [15:0]                 div_dvs;
	logic [fcc_pkg::DIV_W-1:0]   div_quot;
	logic [15:0]                 div_rem;
	logic                        div_done;
	logic                        out_free;
	logic                        sat_hi;
	logic                        sat_lo;

	assign cs_eff   = (csize_q == '0) ? fcc_pkg::CSIZE_W'(1) : csize_q;
	assign fs_ext   = $signed({{(SW-32){1'b0}}, fsize_q});
	assign pos_ext  = $signed({{(SW-32){1'b0}}, pos_q});
	assign rest_ext = $signed({{(SW-16){1'b0}}, rest_q});
	assign out_free = ~out_valid_q | ~out_stall;

	fcc_table u_table (
		.clk          (clk),
		.we           (cmd.op == fcc_pkg::DP_LOAD),
		.pair_index   (pidx_q),
		.packed_bytes (pbytes_q),
		.raddr        (cur_q),
		.rdata        (tbl_rdata)
	);

	assign div_start = (cmd.op == fcc_pkg::DP_SK_LONG) || (cmd.op == fcc_pkg::DP_WK_MOD);
	assign div_dvd   = (cmd.op == fcc_pkg::DP_WK_MOD) ? steps_q
	                 : offs_q[fcc_pkg::DIV_W-1:0] - fcc_pkg::DIV_W'(rest_q);
	assign div_dvs   = (cmd.op == fcc_pkg::DP_WK_MOD) ? lam_q : cs_eff;

	fcc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.quotient  (div_quot),
		.remainder (div_rem),
		.done      (div_done)
	);

	always_comb begin
		stat.act        = act_q;
		stat.cur_bad    = (cur_q >= limit_q);
		stat.off_in     = (coff_q < cs_eff);
		stat.at_eof     = (pos_q >= fsize_q);
		stat.short_seek = (offs_q < rest_ext);
		stat.div_done   = div_done;
		stat.steps_zero = (steps_q == '0);
		stat.cyc_hit    = ~cyc_q && (lam_q != '0) && (cur_q == saved_q);
		stat.next_bad   = (tbl_rdata >= limit_q);
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			coff_q      <= '0;
			pos_q       <= '0;
			csize_q     <= fcc_pkg::CSIZE_RST;
			limit_q     <= fcc_pkg::LIMIT_RST;
			start_q     <= '0;
			fsize_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					fcc_pkg::REG_CLUSTER_SIZE:  csize_q <= cfg_data[15:0];
					fcc_pkg::REG_CLUSTER_LIMIT: limit_q <= cfg_data[11:0];
					fcc_pkg::REG_START_CLUSTER: start_q <= cfg_data[11:0];
					fcc_pkg::REG_FILE_SIZE:     fsize_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				fcc_pkg::DP_RD_FOLLOW: begin
					cur_q  <= tbl_rdata;
					coff_q <= '0;
				end
				fcc_pkg::DP_RD_ADDR: begin
					pos_q  <= pos_q + 1'b1;
					coff_q <= coff_q + 1'b1;
				end
				fcc_pkg::DP_SK_MAX: begin
					if (org_q == fcc_pkg::ORG_START) begin
						pos_q  <= '0;
						cur_q  <= start_q;
						coff_q <= '0;
					end
				end
				fcc_pkg::DP_SK_NEG: begin
					// backward past the cursor: rewind and measure from the start
					if (offs_q[SW-1]) begin
						pos_q  <= '0;
						cur_q  <= start_q;
						coff_q <= '0;
					end
				end
				fcc_pkg::DP_SK_SHORT: begin
					coff_q <= coff_q + offs_q[15:0];
					pos_q  <= pos_q + offs_q[31:0];
				end
				fcc_pkg::DP_WK_NEXT: begin
					cur_q <= tbl_rdata;
				end
				fcc_pkg::DP_WK_BAD: begin
					cur_q <= tbl_rdata;
					if (!first_q) begin
						pos_q <= acc_q;
					end
				end
				fcc_pkg::DP_WK_FIN: begin
					coff_q <= drem_q;
					pos_q  <= pos_q + offs_q[31:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			fcc_pkg::DP_CAPTURE: begin
				act_q    <= action;
				org_q    <= seek_origin;
				pidx_q   <= pair_index;
				pbytes_q <= packed_bytes;
				offs_q   <= {{(SW-32){seek_offset[31]}}, seek_offset};
				res_q    <= '0;
				addr_q   <= '0;
			end
			fcc_pkg::DP_RD_MUL: begin
				mul_q <= fcc_pkg::ADDR_W'(cur_q) * fcc_pkg::ADDR_W'(cs_eff);
			end
			fcc_pkg::DP_RD_ADDR: begin
				addr_q <= mul_q + fcc_pkg::ADDR_W'(coff_q);
			end
			fcc_pkg::DP_SK_MAX: begin
				maxoff_q <= (org_q == fcc_pkg::ORG_START) ? fs_ext : fs_ext - pos_ext;
			end
			fcc_pkg::DP_SK_ORG: begin
				if (org_q == fcc_pkg::ORG_END) begin
					offs_q <= maxoff_q - offs_q;
				end
			end
			fcc_pkg::DP_SK_CLAMP: begin
				if (offs_q > maxoff_q) begin
					res_q  <= offs_q - maxoff_q;
					offs_q <= maxoff_q;
				end
			end
			fcc_pkg::DP_SK_NEG: begin
				if (offs_q[SW-1]) begin
					offs_q <= offs_q + pos_ext;
				end
			end
			fcc_pkg::DP_SK_NEG2: begin
				if (offs_q[SW-1]) begin
					res_q  <= offs_q;
					offs_q <= '0;
				end
			end
			fcc_pkg::DP_SK_REST: begin
				rest_q <= (cs_eff > coff_q) ? cs_eff - coff_q : '0;
			end
			fcc_pkg::DP_SK_LONG: begin
				acc_q <= pos_q + fcc_pkg::POS_W'(rest_q);
			end
			fcc_pkg::DP_SK_ACC: begin
				// start one cluster back so each good step adds a cluster
				acc_q <= acc_q - fcc_pkg::POS_W'(cs_eff);
			end
			fcc_pkg::DP_WK_INIT: begin
				steps_q <= div_quot + fcc_pkg::STEP_W'(1);
				drem_q  <= div_rem;
				saved_q <= cur_q;
				lam_q   <= '0;
				pow_q   <= 16'd1;
				cyc_q   <= 1'b0;
				first_q <= 1'b1;
			end
			fcc_pkg::DP_WK_STEP: begin
				steps_q <= steps_q - 1'b1;
				// move the loop checkpoint at each power of two
				if (lam_q == pow_q) begin
					saved_q <= cur_q;
					lam_q   <= 16'd1;
					pow_q   <= {pow_q[14:0], 1'b0};
				end else begin
					lam_q <= lam_q + 1'b1;
				end
			end
			fcc_pkg::DP_WK_NEXT: begin
				acc_q   <= acc_q + fcc_pkg::POS_W'(cs_eff);
				first_q <= 1'b0;
			end
			fcc_pkg::DP_WK_MOD: begin
				cyc_q <= 1'b1;
			end
			fcc_pkg::DP_WK_SETREM: begin
				steps_q <= fcc_pkg::STEP_W'(div_rem);
			end
			default: ;
		endcase
		if (cmd.op == fcc_pkg::DP_CAPTURE) begin
			st_q <= fcc_pkg::STAT_OK;
		end else if (cmd.st_we) begin
			st_q <= cmd.st;
		end
	end

	assign sat_hi = ~res_q[SW-1] & (|res_q[SW-2:31]);
	assign sat_lo = res_q[SW-1] & ~(&res_q[SW-2:31]);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ost_q   <= st_q;
			oaddr_q <= addr_q;
			ores_q  <= sat_hi ? 32'sh7fffffff : sat_lo ? 32'sh80000000 : res_q[31:0];
			opos_q  <= pos_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = ost_q;
	assign byte_address = oaddr_q;
	assign residual     = ores_q;
	assign position     = opos_q;

endmodule

// ===== rtl/fcc_ctrl.sv =====
// Controller: sequences load, read and seek transactions through the datapath.
module fcc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fcc_pkg::dp_stat_t  stat,
	output fcc_pkg::dp_cmd_t   cmd
);

	fcc_pkg::ctrl_state_t state_q;
	fcc_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fcc_pkg::ST_IDLE: begin
				if (in_valid) state_d = fcc_pkg::ST_DISPATCH;
			end
			fcc_pkg::ST_DISPATCH: begin
				case (stat.act)
					fcc_pkg::ACT_READ: state_d = fcc_pkg::ST_RD_CHK;
					fcc_pkg::ACT_SEEK: state_d = fcc_pkg::ST_SK_MAX;
					default:           state_d = fcc_pkg::ST_DONE;
				endcase
			end
			fcc_pkg::ST_RD_CHK: begin
				if (stat.cur_bad || (stat.off_in && stat.at_eof)) begin
					state_d = fcc_pkg::ST_DONE;
				end else if (stat.off_in) begin
					state_d = fcc_pkg::ST_RD_ADDR;
				end else begin
					state_d = fcc_pkg::ST_RD_FOL;
				end
			end
			fcc_pkg::ST_RD_FOL:   state_d = fcc_pkg::ST_RD_CHK;
			fcc_pkg::ST_RD_ADDR:  state_d = fcc_pkg::ST_DONE;
			fcc_pkg::ST_SK_MAX:   state_d = fcc_pkg::ST_SK_ORG;
			fcc_pkg::ST_SK_ORG:   state_d = fcc_pkg::ST_SK_CLAMP;
			fcc_pkg::ST_SK_CLAMP: state_d = fcc_pkg::ST_SK_NEG;
			fcc_pkg::ST_SK_NEG:   state_d = fcc_pkg::ST_SK_NEG2;
			fcc_pkg::ST_SK_NEG2:  state_d = fcc_pkg::ST_SK_REST;
			fcc_pkg::ST_SK_REST:  state_d = fcc_pkg::ST_SK_DIST;
			fcc_pkg::ST_SK_DIST: begin
				state_d = stat.short_seek ? fcc_pkg::ST_DONE : fcc_pkg::ST_SK_ACC;
			end
			fcc_pkg::ST_SK_ACC: state_d = fcc_pkg::ST_SK_DIV;
			fcc_pkg::ST_SK_DIV: begin
				if (stat.div_done) state_d = fcc_pkg::ST_WK_CHK;
			end
			fcc_pkg::ST_WK_CHK: begin
				if (stat.steps_zero) begin
					state_d = fcc_pkg::ST_DONE;
				end else if (stat.cyc_hit) begin
					state_d = fcc_pkg::ST_WK_MODW;
				end else begin
					state_d = fcc_pkg::ST_WK_RD;
				end
			end
			fcc_pkg::ST_WK_RD: begin
				state_d = stat.next_bad ? fcc_pkg::ST_DONE : fcc_pkg::ST_WK_CHK;
			end
			fcc_pkg::ST_WK_MODW: begin
				if (stat.div_done) state_d = fcc_pkg::ST_WK_CHK;
			end
			fcc_pkg::ST_DONE: begin
				if (stat.out_free) state_d = fcc_pkg::ST_IDLE;
			end
			default: state_d = fcc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = fcc_pkg::DP_NOP;
		cmd.st_we = 1'b0;
		cmd.st    = fcc_pkg::STAT_OK;
		cmd.emit  = 1'b0;
		in_stall  = (state_q != fcc_pkg::ST_IDLE);
		case (state_q)
			fcc_pkg::ST_IDLE: begin
				if (in_valid) cmd.op = fcc_pkg::DP_CAPTURE;
			end
			fcc_pkg::ST_DISPATCH: begin
				if (stat.act == fcc_pkg::ACT_LOAD) cmd.op = fcc_pkg::DP_LOAD;
			end
			fcc_pkg::ST_RD_CHK: begin
				if (stat.cur_bad) begin
					cmd.st_we = 1'b1;
					cmd.st    = fcc_pkg::STAT_BAD;
				end else if (stat.off_in && stat.at_eof) begin
					cmd.st_we = 1'b1;
					cmd.st    = fcc_pkg::STAT_EOF;
				end else if (stat.off_in) begin
					cmd.op = fcc_pkg::DP_RD_MUL;
				end
			end
			fcc_pkg::ST_RD_FOL:   cmd.op = fcc_pkg::DP_RD_FOLLOW;
			fcc_pkg::ST_RD_ADDR:  cmd.op = fcc_pkg::DP_RD_ADDR;
			fcc_pkg::ST_SK_MAX:   cmd.op = fcc_pkg::DP_SK_MAX;
			fcc_pkg::ST_SK_ORG:   cmd.op = fcc_pkg::DP_SK_ORG;
			fcc_pkg::ST_SK_CLAMP: cmd.op = fcc_pkg::DP_SK_CLAMP;
			fcc_pkg::ST_SK_NEG:   cmd.op = fcc_pkg::DP_SK_NEG;
			fcc_pkg::ST_SK_NEG2:  cmd.op = fcc_pkg::DP_SK_NEG2;
			fcc_pkg::ST_SK_REST:  cmd.op = fcc_pkg::DP_SK_REST;
			fcc_pkg::ST_SK_DIST: begin
				cmd.op = stat.short_seek ? fcc_pkg::DP_SK_SHORT : fcc_pkg::DP_SK_LONG;
			end
			fcc_pkg::ST_SK_ACC: cmd.op = fcc_pkg::DP_SK_ACC;
			fcc_pkg::ST_SK_DIV: begin
				if (stat.div_done) cmd.op = fcc_pkg::DP_WK_INIT;
			end
			fcc_pkg::ST_WK_CHK: begin
				if (stat.steps_zero) begin
					cmd.op = fcc_pkg::DP_WK_FIN;
				end else if (stat.cyc_hit) begin
					cmd.op = fcc_pkg::DP_WK_MOD;
				end else begin
					cmd.op = fcc_pkg::DP_WK_STEP;
				end
			end
			fcc_pkg::ST_WK_RD: begin
				if (stat.next_bad) begin
					cmd.op    = fcc_pkg::DP_WK_BAD;
					cmd.st_we = 1'b1;
					cmd.st    = fcc_pkg::STAT_BAD;
				end else begin
					cmd.op = fcc_pkg::DP_WK_NEXT;
				end
			end
			fcc_pkg::ST_WK_MODW: begin
				if (stat.div_done) cmd.op = fcc_pkg::DP_WK_SETREM;
			end
			fcc_pkg::ST_DONE: begin
				cmd.emit = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule
